// ===== design/cwt_pkg.sv =====
// Shared constants, types and helper functions for the cubic window target block.
`default_nettype none

package cwt_pkg;

  // Configuration register fields.
  localparam int CFG_W      = 10;
  localparam int HZ_W       = 4;
  localparam int BETA_SHIFT = 10;

  localparam logic [CFG_W-1:0] BETA_RESET  = 10'd717;
  localparam logic [CFG_W-1:0] SCALE_RESET = 10'd410;
  localparam logic [HZ_W-1:0]  HZ_RESET    = 4'd10;

  // Configuration port geometry.
  localparam int ADDR_W   = 4;
  localparam int ADDR_LSB = 2;
  localparam int PDATA_W  = 32;

  // Cube shift sh = SH_BASE + 3 * min(hz, HZ_MAX).
  localparam int SH_W    = 6;
  localparam int SH_BASE = 10;
  localparam logic [HZ_W-1:0] HZ_MAX = 4'd10;

  // Datapath widths.
  localparam int F_W    = 40;  // floor(2^sh / S) - 1 is below 2^40
  localparam int F_HALF = 20;
  localparam int A_W    = 63;  // cube root argument, saturated to 2^63 - 1
  localparam int ROOT_W = 21;  // cube root of a 63-bit value
  localparam int CAP_W  = 40;  // quotient cap is 2^40
  localparam int OUT_W  = 32;
  localparam int RT_W   = 8;   // remainder of the ms to tick conversion

  // Ticks: t = floor(ms * 128 / 125).
  localparam int TICK_DEN = 125;

  // Pipeline depth of each section, in registers.
  localparam int FRONT_LAT = 5;
  localparam int CBRT_LAT  = ROOT_W;
  localparam int BACK_LAT  = 8;
  localparam int PIPE_LAT  = FRONT_LAT + CBRT_LAT + BACK_LAT;

  typedef enum logic [1:0] {
    REG_BETA  = 2'd0,
    REG_SCALE = 2'd1,
    REG_HZ    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_LOAD = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_t;

  // A scale of zero behaves as one.
  function automatic logic [CFG_W-1:0] scale_eff(input logic [CFG_W-1:0] scale);
    scale_eff = (scale == '0) ? CFG_W'(1) : scale;
  endfunction

  // Cube shift from the exponent register, exponent clamped to HZ_MAX.
  function automatic logic [SH_W-1:0] shift_of(input logic [HZ_W-1:0] hz);
    logic [HZ_W-1:0] hz_c;
    hz_c = (hz > HZ_MAX) ? HZ_MAX : hz;
    shift_of = SH_W'(SH_BASE) + SH_W'({hz_c, 1'b0}) + SH_W'(hz_c);
  endfunction

endpackage

`default_nettype wire

// ===== design/cwt_recip_div.sv =====
// Bit-serial divider that forms F = floor(2^sh / S) - 1 after reset and each register write.
`default_nettype none

module cwt_recip_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       kick,
  input  logic [cwt_pkg::CFG_W-1:0]  scale,
  input  logic [cwt_pkg::HZ_W-1:0]   hz,
  output logic [cwt_pkg::F_W-1:0]    f,
  output logic                       busy
);
  import cwt_pkg::*;

  div_state_t       state, state_next;
  logic [SH_W-1:0]  cnt;
  logic             first;
  logic [CFG_W-1:0] divisor;
  logic [CFG_W-1:0] rem;
  logic [CFG_W-1:0] rem_next;
  logic [F_W:0]     quo;
  logic [F_W:0]     quo_next;
  logic [CFG_W:0]   trial;
  logic             take;

  // The dividend is a one followed by sh zeros; it enters one bit per step.
  assign trial    = {rem, first};
  assign take     = trial >= {1'b0, divisor};
  assign rem_next = take ? CFG_W'(trial - {1'b0, divisor}) : trial[CFG_W-1:0];
  assign quo_next = {quo[F_W-1:0], take};

  always_comb begin
    state_next = state;
    case (state)
      DIV_LOAD: state_next = DIV_RUN;
      DIV_RUN:  if (cnt == '0) state_next = DIV_DONE;
      DIV_DONE: state_next = DIV_DONE;
      default:  state_next = DIV_LOAD;
    endcase
    if (kick) state_next = DIV_LOAD;
  end

  always_comb begin
    case (state)
      DIV_DONE: busy = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_LOAD) begin
      divisor <= scale_eff(scale);
      cnt     <= shift_of(hz);
      first   <= 1'b1;
      rem     <= '0;
      quo     <= '0;
    end else if (state == DIV_RUN) begin
      first <= 1'b0;
      rem   <= rem_next;
      quo   <= quo_next;
      cnt   <= cnt - SH_W'(1);
      if (cnt == '0) begin
        f <= (quo_next == '0) ? '0 : F_W'(quo_next - (F_W + 1)'(1));
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/cwt_front.sv =====
// Front pipeline: decreased window, time in ticks and the saturated cube root argument.
`default_nettype none

module cwt_front #(
  parameter int WINDOW_BITS = 20,
  parameter int TIME_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [WINDOW_BITS-1:0]    window,
  input  logic [TIME_BITS-1:0]      ms,
  input  logic [cwt_pkg::CFG_W-1:0] beta,
  input  logic [cwt_pkg::F_W-1:0]   f,
  output logic                      out_valid,
  output logic [cwt_pkg::A_W-1:0]   radicand,
  output logic [WINDOW_BITS-1:0]    out_window,
  output logic [TIME_BITS:0]        ticks
);
  import cwt_pkg::*;

  // floor(m / 125) for m = 3 * ms is found as floor(m * RECIP / 2^M_W), which is
  // exact or one short; the remainder check in the last stage fixes it.
  localparam int M_W  = TIME_BITS + 2;
  localparam int RC_W = TIME_BITS - 4;
  localparam int TK_W = TIME_BITS + 1;
  localparam logic [RC_W-1:0] RECIP = RC_W'((64'd1 << M_W) / 64'(TICK_DEN));
  localparam int P_W  = F_HALF + WINDOW_BITS;
  localparam int AX_W = (F_W + WINDOW_BITS + 1 > A_W + 1) ? F_W + WINDOW_BITS + 1 : A_W + 1;

  logic v1, v2, v3, v4, v5;

  logic [WINDOW_BITS-1:0]       w1, w2, w3, w4;
  logic [TIME_BITS-1:0]         ms1, ms2, ms3, ms4;
  logic [CFG_W+WINDOW_BITS-1:0] bw2;
  logic [M_W+RC_W-1:0]          pt2;
  logic [WINDOW_BITS-1:0]       d3;
  logic [RC_W-1:0]              q03, q04;
  logic [P_W-1:0]               pa_lo4, pa_hi4;
  logic [RT_W-1:0]              rt4;

  logic [M_W-1:0]  m1;
  logic [RT_W-1:0] ms8, q8;
  logic [AX_W-1:0] asum;

  assign m1   = M_W'(ms1) + M_W'({ms1, 1'b0});
  assign ms8  = RT_W'(ms3);
  assign q8   = RT_W'(q03);
  assign asum = AX_W'(pa_lo4) + (AX_W'(pa_hi4) << F_HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    // Input register.
    w1  <= window;
    ms1 <= ms;
    // beta * W and the reciprocal product for the tick conversion.
    w2  <= w1;
    ms2 <= ms1;
    bw2 <= (CFG_W + WINDOW_BITS)'(beta) * (CFG_W + WINDOW_BITS)'(w1);
    pt2 <= (M_W + RC_W)'(m1) * (M_W + RC_W)'(RECIP);
    // D = W - floor(beta * W / 1024) and the estimated tick quotient.
    w3  <= w2;
    ms3 <= ms2;
    d3  <= w2 - WINDOW_BITS'(bw2 >> BETA_SHIFT);
    q03 <= pt2[M_W +: RC_W];
    // F * D as two partial products; remainder of 3 * ms taken modulo 256.
    w4     <= w3;
    ms4    <= ms3;
    q04    <= q03;
    pa_lo4 <= P_W'(f[F_HALF-1:0]) * P_W'(d3);
    pa_hi4 <= P_W'(f[F_W-1:F_HALF]) * P_W'(d3);
    rt4    <= ms8 + ms8 + ms8 - q8 * RT_W'(TICK_DEN);
    // Saturated argument and corrected tick count.
    out_window <= w4;
    radicand   <= (|asum[AX_W-1:A_W]) ? '1 : asum[A_W-1:0];
    ticks      <= TK_W'(ms4) + TK_W'(q04) + TK_W'(rt4 >= RT_W'(TICK_DEN));
  end

  assign out_valid = v5;

endmodule

`default_nettype wire

// ===== design/cwt_cbrt.sv =====
// Pipelined integer cube root, one result bit per stage.
`default_nettype none

module cwt_cbrt #(
  parameter int SIDE_W = 37
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [cwt_pkg::A_W-1:0]    radicand,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_valid,
  output logic [cwt_pkg::ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]          side_out
);
  import cwt_pkg::*;

  localparam int T_W  = A_W + 3;
  localparam int SQ_W = 2 * ROOT_W;

  // Each stage holds the partial root r, its square and a - r^3.
  logic              vld  [1:ROOT_W];
  logic [A_W-1:0]    rem  [1:ROOT_W];
  logic [ROOT_W-1:0] rt   [1:ROOT_W];
  logic [SQ_W-1:0]   rsq  [1:ROOT_W];
  logic [SIDE_W-1:0] side [1:ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int B = ROOT_W - 1 - i;

    logic              cur_v;
    logic [A_W-1:0]    cur_rem;
    logic [ROOT_W-1:0] cur_rt;
    logic [SQ_W-1:0]   cur_rsq;
    logic [SIDE_W-1:0] cur_side;
    logic [T_W-1:0]    rsq_x, rt_x, step;
    logic              take;

    if (i == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = radicand;
      assign cur_rt   = '0;
      assign cur_rsq  = '0;
      assign cur_side = side_in;
    end else begin : g_next
      assign cur_v    = vld[i];
      assign cur_rem  = rem[i];
      assign cur_rt   = rt[i];
      assign cur_rsq  = rsq[i];
      assign cur_side = side[i];
    end

    // (r + 2^B)^3 - r^3 = 3 r^2 2^B + 3 r 2^2B + 2^3B
    assign rsq_x = T_W'(cur_rsq);
    assign rt_x  = T_W'(cur_rt);
    assign step  = (((rsq_x << 1) + rsq_x) << B) + (((rt_x << 1) + rt_x) << (2 * B))
                 + (T_W'(1) << (3 * B));
    assign take  = T_W'(cur_rem) >= step;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      side[i+1] <= cur_side;
      if (take) begin
        rem[i+1] <= cur_rem - A_W'(step);
        rt[i+1]  <= cur_rt | (ROOT_W'(1) << B);
        rsq[i+1] <= cur_rsq + (SQ_W'(cur_rt) << (B + 1)) + (SQ_W'(1) << (2 * B));
      end else begin
        rem[i+1] <= cur_rem;
        rt[i+1]  <= cur_rt;
        rsq[i+1] <= cur_rsq;
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = side[ROOT_W];

endmodule

`default_nettype wire

// ===== design/cwt_back.sv =====
// Back pipeline: scaled cube of the offset, shift by sh and saturated target.
`default_nettype none

module cwt_back #(
  parameter int WINDOW_BITS = 20,
  parameter int TIME_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [cwt_pkg::ROOT_W-1:0] root,
  input  logic [WINDOW_BITS-1:0]     window,
  input  logic [TIME_BITS:0]         ticks,
  input  logic [cwt_pkg::CFG_W-1:0]  scale,
  input  logic [cwt_pkg::HZ_W-1:0]   hz,
  output logic                       out_valid,
  output logic [cwt_pkg::OUT_W-1:0]  target,
  output logic                       clipped
);
  import cwt_pkg::*;

  localparam int OW   = (TIME_BITS + 1 > ROOT_W) ? TIME_BITS + 1 : ROOT_W;
  localparam int SO_W = OW + CFG_W;
  localparam int SOL  = (SO_W + 1) / 2;
  localparam int SOH  = SO_W - SOL;
  localparam int HP_W = OW + SO_W;
  localparam int Q_W  = 3 * OW + CFG_W;
  localparam int DL_W = CAP_W + 1;
  localparam int SM_W = CAP_W + 2;

  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic [WINDOW_BITS-1:0] w1, w2, w3, w4, w5, w6, w7;
  logic sub1, sub2, sub3, sub4, sub5, sub6, sub7;

  logic [OW-1:0]      offs1;
  logic [2*OW-1:0]    sq2;
  logic [SO_W-1:0]    so2;
  logic [OW+SOL-1:0]  pp_ll3, pp_hl3;
  logic [OW+SOH-1:0]  pp_lh3, pp_hh3;
  logic [HP_W-1:0]    lo4, hi4;
  logic [Q_W-1:0]     q5;
  logic               big6, frac6;
  logic [CAP_W-1:0]   dl6;
  logic [DL_W-1:0]    delta7;

  logic [OW-1:0]      root_x, ticks_x;
  logic [Q_W-1:0]     shifted, low_mask;
  logic [SH_W-1:0]    sh;
  logic [SM_W-1:0]    w_x, delta_x, sum_x;

  assign root_x   = OW'(root);
  assign ticks_x  = OW'(ticks);
  assign sh       = shift_of(hz);
  assign shifted  = q5 >> sh;
  assign low_mask = ~({Q_W{1'b1}} << sh);
  assign w_x      = SM_W'(w7);
  assign delta_x  = SM_W'(delta7);
  assign sum_x    = w_x + delta_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    w1 <= window;
    w2 <= w1;
    w3 <= w2;
    w4 <= w3;
    w5 <= w4;
    w6 <= w5;
    w7 <= w6;
    sub2 <= sub1;
    sub3 <= sub2;
    sub4 <= sub3;
    sub5 <= sub4;
    sub6 <= sub5;
    sub7 <= sub6;

    // Distance to the plateau.
    sub1  <= ticks_x < root_x;
    offs1 <= (ticks_x < root_x) ? root_x - ticks_x : ticks_x - root_x;

    // offs^2 and S * offs side by side.
    sq2 <= (2 * OW)'(offs1) * (2 * OW)'(offs1);
    so2 <= SO_W'(scale_eff(scale)) * SO_W'(offs1);

    // Four partial products of offs^2 * (S * offs).
    pp_ll3 <= (OW + SOL)'(sq2[OW-1:0]) * (OW + SOL)'(so2[SOL-1:0]);
    pp_lh3 <= (OW + SOH)'(sq2[OW-1:0]) * (OW + SOH)'(so2[SO_W-1:SOL]);
    pp_hl3 <= (OW + SOL)'(sq2[2*OW-1:OW]) * (OW + SOL)'(so2[SOL-1:0]);
    pp_hh3 <= (OW + SOH)'(sq2[2*OW-1:OW]) * (OW + SOH)'(so2[SO_W-1:SOL]);

    // Low and high halves of offs^2, each times S * offs.
    lo4 <= HP_W'(pp_ll3) + (HP_W'(pp_lh3) << SOL);
    hi4 <= HP_W'(pp_hl3) + (HP_W'(pp_hh3) << SOL);

    q5 <= Q_W'(lo4) + (Q_W'(hi4) << OW);

    // Quotient by 2^sh, its cap flag and whether anything was shifted out.
    dl6   <= shifted[CAP_W-1:0];
    big6  <= |shifted[Q_W-1:CAP_W];
    frac6 <= |(q5 & low_mask);

    // Below the plateau the quotient rounds up so the target truncates toward zero.
    delta7 <= big6 ? (DL_W'(1) << CAP_W)
                   : DL_W'(dl6) + DL_W'(sub6 && frac6);

    if (sub7) begin
      if (delta_x > w_x) begin
        target  <= '0;
        clipped <= 1'b1;
      end else begin
        target  <= OUT_W'(w_x - delta_x);
        clipped <= 1'b0;
      end
    end else begin
      if (sum_x > SM_W'({OUT_W{1'b1}})) begin
        target  <= '1;
        clipped <= 1'b1;
      end else begin
        target  <= sum_x[OUT_W-1:0];
        clipped <= 1'b0;
      end
    end
  end

  assign out_valid = v8;

endmodule

`default_nettype wire

// ===== design/cubic_window_target.sv =====
// Top level of the CUBIC window target pipeline with its register port.
`default_nettype none

// Channel   Handshake                        Payload
// --------  -------------------------------  ----------------------------------------
// input     start && !busy accepts a beat    max_window, elapsed_ms
// result    done high for one cycle           target_window, clipped
// config    psel, penable, pwrite, pready     paddr (0 beta, 4 scale, 8 hz), pwdata
//
// One beat enters per cycle whenever busy is low; each accepted beat passes
// through 5 front stages, 21 cube root stages (one root bit each) and 8 back
// stages before its result appears. The receiver cannot stall, so the
// pipeline never holds. After reset and after every register write, busy is
// high while a serial divider forms floor(2^sh / S) - 1.

module cubic_window_target #(
  parameter int WINDOW_BITS = 20,
  parameter int TIME_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [WINDOW_BITS-1:0]       max_window,
  input  logic [TIME_BITS-1:0]         elapsed_ms,
  output logic                         done,
  output logic [cwt_pkg::OUT_W-1:0]    target_window,
  output logic                         clipped,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cwt_pkg::ADDR_W-1:0]   paddr,
  input  logic [cwt_pkg::PDATA_W-1:0]  pwdata,
  output logic [cwt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import cwt_pkg::*;

  localparam int SIDE_W = WINDOW_BITS + TIME_BITS + 1;

  // Configuration registers, stored as written; clamping happens where used.
  logic [CFG_W-1:0] beta;
  logic [CFG_W-1:0] scale;
  logic [HZ_W-1:0]  hz;

  logic     cfg_write;
  logic     accept;
  reg_idx_t reg_sel;

  logic [F_W-1:0] f;

  logic                   fr_valid;
  logic [A_W-1:0]         fr_radicand;
  logic [WINDOW_BITS-1:0] fr_window;
  logic [TIME_BITS:0]     fr_ticks;

  logic                   cb_valid;
  logic [ROOT_W-1:0]      cb_root;
  logic [SIDE_W-1:0]      cb_side;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta  <= BETA_RESET;
      scale <= SCALE_RESET;
      hz    <= HZ_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_BETA:  beta  <= pwdata[CFG_W-1:0];
        REG_SCALE: scale <= pwdata[CFG_W-1:0];
        REG_HZ:    hz    <= pwdata[HZ_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BETA:  prdata = PDATA_W'(beta);
      REG_SCALE: prdata = PDATA_W'(scale);
      REG_HZ:    prdata = PDATA_W'(hz);
      default:   prdata = '0;
    endcase
  end

  // Any register write restarts the divider, which holds busy until F is ready.
  cwt_recip_div u_div (
    .clk   (clk),
    .rst   (rst),
    .kick  (cfg_write),
    .scale (scale),
    .hz    (hz),
    .f     (f),
    .busy  (busy)
  );

  cwt_front #(
    .WINDOW_BITS (WINDOW_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .window     (max_window),
    .ms         (elapsed_ms),
    .beta       (beta),
    .f          (f),
    .out_valid  (fr_valid),
    .radicand   (fr_radicand),
    .out_window (fr_window),
    .ticks      (fr_ticks)
  );

  // The window and tick count ride alongside the root stages.
  cwt_cbrt #(
    .SIDE_W (SIDE_W)
  ) u_cbrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .radicand  (fr_radicand),
    .side_in   ({fr_window, fr_ticks}),
    .out_valid (cb_valid),
    .root      (cb_root),
    .side_out  (cb_side)
  );

  cwt_back #(
    .WINDOW_BITS (WINDOW_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cb_valid),
    .root      (cb_root),
    .window    (cb_side[SIDE_W-1:TIME_BITS+1]),
    .ticks     (cb_side[TIME_BITS:0]),
    .scale     (scale),
    .hz        (hz),
    .out_valid (done),
    .target    (target_window),
    .clipped   (clipped)
  );

  // Every accepted beat comes out after the fixed pipeline depth.
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("accepted beat did not produce a result");

  // No result without a beat accepted exactly one pipeline depth earlier.
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LAT))
    else $error("result without a matching input beat");

  // Saturation only ever lands on one of the two range limits.
  a_clip_limits: assert property (@(posedge clk) disable iff (rst)
    (done && clipped) |-> (target_window == '0 || target_window == '1))
    else $error("clipped result is not at a range limit");

  // A register write holds off new beats while F is recomputed.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> busy)
    else $error("busy not raised after a register write");

endmodule

`default_nettype wire
